// File: hw/rtl/ring_masked_hsv_color_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
`ifndef RING_MASKED_HSV_COLOR_CLASSIFIER_DEFINES_SVH
`define RING_MASKED_HSV_COLOR_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HSVC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsvc same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define HSVC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsvc next-cycle check failed");

`endif

// File: hw/rtl/hsvc_pkg.sv
// Shared constants and types of the ring-masked HSV color classifier.
`timescale 1ns / 1ps
package hsvc_pkg;

   localparam int COORD_BITS = 10;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 1;
   localparam int CHAN_BITS  = 8;

   localparam int REQ_BITS       = 2 * COORD_BITS + 3 * CHAN_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS       = 2 + 3 * CHAN_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   localparam int REG_INDEX_BITS = 3;
   localparam int CSR_ADDR_BITS  = REG_INDEX_BITS + 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [REG_INDEX_BITS-1:0] REG_HUE_LOW    = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_HUE_HIGH   = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_SAT_BOUNDS = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_VAL_BOUNDS = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_X   = 3'd4;
   localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_Y   = 3'd5;
   localparam logic [REG_INDEX_BITS-1:0] REG_INNER_R    = 3'd6;
   localparam logic [REG_INDEX_BITS-1:0] REG_OUTER_R    = 3'd7;

   // Divider operands: 255*2*df + mx and 2*h*df + df both stay below 2^17.
   localparam int DIV_NUM_BITS        = 17;
   localparam int DIV_DEN_BITS        = 9;
   localparam int QUO_BITS            = 8;
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = QUO_BITS / DIV_STEPS_PER_STAGE;

   // Stage 0: min/max and deltas, stage 1: squares and divider operands,
   // then the divider stages, then the output register.
   localparam int DIV_FIRST   = 2;
   localparam int DIV_LAST    = DIV_FIRST + DIV_STAGES - 1;
   localparam int PIPE_STAGES = DIV_LAST + 2;
   localparam int OUT_STAGE   = PIPE_STAGES - 1;

   localparam logic [CHAN_BITS-1:0] HUE_TOP  = 8'd179;
   localparam logic [CHAN_BITS-1:0] HUE_WRAP = 8'd180;

   typedef struct packed {
      logic [CHAN_BITS-1:0]  hue_low;
      logic [CHAN_BITS-1:0]  hue_high;
      logic [CHAN_BITS-1:0]  sat_min;
      logic [CHAN_BITS-1:0]  sat_max;
      logic [CHAN_BITS-1:0]  val_min;
      logic [CHAN_BITS-1:0]  val_max;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [COORD_BITS-1:0] inner_r;
      logic [COORD_BITS-1:0] outer_r;
   } cfg_type;

   typedef struct packed {
      logic [DIV_NUM_BITS-1:0] s_num;
      logic [DIV_DEN_BITS-1:0] s_den;
      logic [DIV_NUM_BITS-1:0] h_num;
      logic [DIV_DEN_BITS-1:0] h_den;
      logic [CHAN_BITS-1:0]    val;
      logic                    s_zero;
      logic                    h_zero;
   } prep_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] val;
      logic                 s_zero;
      logic                 h_zero;
      logic                 in_ring;
   } side_type;

endpackage

// File: hw/rtl/hsvc_csr.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module hsvc_csr import hsvc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   localparam int RST_CENTER_X = 320;
   localparam int RST_CENTER_Y = 240;
   localparam int RST_OUTER_R  = 1023;

   logic [CHAN_BITS-1:0]   hue_low_ff, hue_high_ff;
   logic [2*CHAN_BITS-1:0] sat_bounds_ff, val_bounds_ff;
   logic [COORD_BITS-1:0]  center_x_ff, center_y_ff, inner_r_ff, outer_r_ff;

   logic                      wr_w;
   logic [REG_INDEX_BITS-1:0] index_w;

   assign csr_pready = 1'b1;
   assign wr_w       = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index_w    = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff    <= '0;
         hue_high_ff   <= HUE_TOP;
         sat_bounds_ff <= 16'hFF00;
         val_bounds_ff <= 16'hFF00;
         center_x_ff   <= COORD_BITS'(RST_CENTER_X);
         center_y_ff   <= COORD_BITS'(RST_CENTER_Y);
         inner_r_ff    <= '0;
         outer_r_ff    <= COORD_BITS'(RST_OUTER_R);
      end else if (wr_w) begin
         case (index_w)
            REG_HUE_LOW:    hue_low_ff    <= csr_pwdata[CHAN_BITS-1:0];
            REG_HUE_HIGH:   hue_high_ff   <= csr_pwdata[CHAN_BITS-1:0];
            REG_SAT_BOUNDS: sat_bounds_ff <= csr_pwdata[2*CHAN_BITS-1:0];
            REG_VAL_BOUNDS: val_bounds_ff <= csr_pwdata[2*CHAN_BITS-1:0];
            REG_CENTER_X:   center_x_ff   <= csr_pwdata[COORD_BITS-1:0];
            REG_CENTER_Y:   center_y_ff   <= csr_pwdata[COORD_BITS-1:0];
            REG_INNER_R:    inner_r_ff    <= csr_pwdata[COORD_BITS-1:0];
            REG_OUTER_R:    outer_r_ff    <= csr_pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index_w)
         REG_HUE_LOW:    csr_prdata = CSR_DATA_BITS'(hue_low_ff);
         REG_HUE_HIGH:   csr_prdata = CSR_DATA_BITS'(hue_high_ff);
         REG_SAT_BOUNDS: csr_prdata = CSR_DATA_BITS'(sat_bounds_ff);
         REG_VAL_BOUNDS: csr_prdata = CSR_DATA_BITS'(val_bounds_ff);
         REG_CENTER_X:   csr_prdata = CSR_DATA_BITS'(center_x_ff);
         REG_CENTER_Y:   csr_prdata = CSR_DATA_BITS'(center_y_ff);
         REG_INNER_R:    csr_prdata = CSR_DATA_BITS'(inner_r_ff);
         REG_OUTER_R:    csr_prdata = CSR_DATA_BITS'(outer_r_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.hue_low  = hue_low_ff;
      cfg.hue_high = hue_high_ff;
      cfg.sat_min  = sat_bounds_ff[CHAN_BITS-1:0];
      cfg.sat_max  = sat_bounds_ff[2*CHAN_BITS-1:CHAN_BITS];
      cfg.val_min  = val_bounds_ff[CHAN_BITS-1:0];
      cfg.val_max  = val_bounds_ff[2*CHAN_BITS-1:CHAN_BITS];
      cfg.center_x = center_x_ff;
      cfg.center_y = center_y_ff;
      cfg.inner_r  = inner_r_ff;
      cfg.outer_r  = outer_r_ff;
   end

endmodule

// File: hw/rtl/hsvc_ring.sv
// Ring membership: center distance, squares and radius compare.
`timescale 1ns / 1ps
module hsvc_ring import hsvc_pkg::*; (
   input  logic                  clock,
   input  logic [1:0]            stage_en,
   input  logic [COORD_BITS-1:0] pix_col,
   input  logic [COORD_BITS-1:0] pix_row,
   input  cfg_type               cfg,
   output logic                  in_ring
);

   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_BITS-1:0]    sqx_ff, sqy_ff, ro2_ff, ri2_ff;
   logic [DIST_BITS-1:0]  dist_w;

   assign dx_in = (pix_col >= cfg.center_x) ? pix_col - cfg.center_x : cfg.center_x - pix_col;
   assign dy_in = (pix_row >= cfg.center_y) ? pix_row - cfg.center_y : cfg.center_y - pix_row;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (stage_en[1]) begin
         sqx_ff <= SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
         sqy_ff <= SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
         ro2_ff <= SQ_BITS'(cfg.outer_r) * SQ_BITS'(cfg.outer_r);
         ri2_ff <= SQ_BITS'(cfg.inner_r) * SQ_BITS'(cfg.inner_r);
      end
   end

   // Inner edge is exclusive, outer edge inclusive.
   assign dist_w  = DIST_BITS'(sqx_ff) + DIST_BITS'(sqy_ff);
   assign in_ring = (dist_w <= DIST_BITS'(ro2_ff)) && (dist_w > DIST_BITS'(ri2_ff));

endmodule

// File: hw/rtl/hsvc_prep.sv
// HSV front end: max, min, hue sector and the divider operands.
`timescale 1ns / 1ps
module hsvc_prep import hsvc_pkg::*; (
   input  logic                 clock,
   input  logic [1:0]           stage_en,
   input  logic [CHAN_BITS-1:0] blue_in,
   input  logic [CHAN_BITS-1:0] green_in,
   input  logic [CHAN_BITS-1:0] red_in,
   output prep_type             prep
);

   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   logic [CHAN_BITS-1:0] mx_in, mn_in, df_in, p_w, q_w, mag_in;
   logic [1:0]           sel_in;
   logic                 neg_in;

   logic [CHAN_BITS-1:0] mx_ff, df_ff, mag_ff;
   logic [1:0]           sel_ff;
   logic                 neg_ff;

   logic [DIV_NUM_BITS-1:0] base_w, term_w, full_w, n_w;
   prep_type                prep_ff, prep_in;

   always_comb begin
      mx_in = red_in;
      if (green_in > mx_in) mx_in = green_in;
      if (blue_in > mx_in) mx_in = blue_in;
      mn_in = red_in;
      if (green_in < mn_in) mn_in = green_in;
      if (blue_in < mn_in) mn_in = blue_in;
      df_in = mx_in - mn_in;
      // Red wins ties, then green.
      if (mx_in == red_in) begin
         sel_in = SEL_RED;
         p_w    = green_in;
         q_w    = blue_in;
      end else if (mx_in == green_in) begin
         sel_in = SEL_GREEN;
         p_w    = blue_in;
         q_w    = red_in;
      end else begin
         sel_in = SEL_BLUE;
         p_w    = red_in;
         q_w    = green_in;
      end
      neg_in = p_w < q_w;
      mag_in = neg_in ? q_w - p_w : p_w - q_w;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mx_ff  <= mx_in;
         df_ff  <= df_in;
         mag_ff <= mag_in;
         sel_ff <= sel_in;
         neg_ff <= neg_in;
      end
   end

   // Half-degree hue times df, folded into 0 .. 180*df.
   always_comb begin
      case (sel_ff)
         SEL_RED:   base_w = '0;
         SEL_GREEN: base_w = DIV_NUM_BITS'(df_ff) * DIV_NUM_BITS'(60);
         SEL_BLUE:  base_w = DIV_NUM_BITS'(df_ff) * DIV_NUM_BITS'(120);
         default:   base_w = '0;
      endcase
      term_w = DIV_NUM_BITS'(mag_ff) * DIV_NUM_BITS'(30);
      full_w = DIV_NUM_BITS'(df_ff) * DIV_NUM_BITS'(180);
      if (!neg_ff) n_w = base_w + term_w;
      else if (base_w >= term_w) n_w = base_w - term_w;
      else n_w = base_w + full_w - term_w;

      prep_in.s_num  = DIV_NUM_BITS'(df_ff) * DIV_NUM_BITS'(510) + DIV_NUM_BITS'(mx_ff);
      prep_in.s_den  = {mx_ff, 1'b0};
      prep_in.h_num  = {n_w[DIV_NUM_BITS-2:0], 1'b0} + DIV_NUM_BITS'(df_ff);
      prep_in.h_den  = {df_ff, 1'b0};
      prep_in.val    = mx_ff;
      prep_in.s_zero = (mx_ff == '0);
      prep_in.h_zero = (df_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) prep_ff <= prep_in;
   end

   assign prep = prep_ff;

endmodule

// File: hw/rtl/hsvc_div.sv
// Pipelined restoring divider, two quotient bits per stage.
`timescale 1ns / 1ps
module hsvc_div import hsvc_pkg::*; (
   input  logic                    clock,
   input  logic [DIV_STAGES-1:0]   stage_en,
   input  logic [DIV_NUM_BITS-1:0] num,
   input  logic [DIV_DEN_BITS-1:0] den,
   output logic [QUO_BITS-1:0]     quo
);

   logic [DIV_NUM_BITS-1:0] rem_ff [DIV_STAGES-1];
   logic [DIV_DEN_BITS-1:0] den_ff [DIV_STAGES-1];
   logic [QUO_BITS-1:0]     quo_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_NUM_BITS-1:0] rem_src, rem_in, trial_w;
      logic [DIV_DEN_BITS-1:0] den_src;
      logic [QUO_BITS-1:0]     quo_src, quo_in;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      // Quotient fits in QUO_BITS, so the top shift never overflows.
      always_comb begin
         rem_in  = rem_src;
         quo_in  = quo_src;
         trial_w = '0;
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            trial_w = DIV_NUM_BITS'(den_src) << (QUO_BITS - 1 - k * DIV_STEPS_PER_STAGE - j);
            if (rem_in >= trial_w) begin
               rem_in = rem_in - trial_w;
               quo_in = quo_in | (QUO_BITS'(1) << (QUO_BITS - 1 - k * DIV_STEPS_PER_STAGE - j));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k]) quo_ff[k] <= quo_in;
      end

      if (k < DIV_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_src;
            end
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

// File: hw/rtl/ring_masked_hsv_color_classifier.sv
// One pixel accepted per clock unless a full pipeline is held by a low rsp_tready.
// Pipeline: min/max and center deltas, squares and divider operands, four divider
// stages of two quotient bits each for hue and saturation, then bound tests.
// Each stage stalls only when it and every stage after it are full and rsp_tready is low.
// Reset clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps
`include "ring_masked_hsv_color_classifier_defines.svh"
module ring_masked_hsv_color_classifier import hsvc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata, low bit up: pix_col, pix_row, blue_in, green_in, red_in, zero pad
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // rsp_tdata, low bit up: color_match, inside_ring, hue_out, sat_out, val_out, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   cfg_type  cfg;
   prep_type prep;
   logic     inside_w;

   logic [PIPE_STAGES-1:0] vld_ff, vld_in, en_w;
   side_type               side_ff [DIV_STAGES];
   side_type               side_in, side_last;

   logic [QUO_BITS-1:0]  s_quo, h_quo;
   logic [CHAN_BITS-1:0] h_sel_w, hue_in, sat_in, val_in;
   logic                 hue_ok_w, match_in;

   logic                 match_ff, inside_out_ff;
   logic [CHAN_BITS-1:0] hue_ff, sat_ff, val_ff;

   hsvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Advance a stage when it is empty or the stage after it advances.
   always_comb begin
      en_w[OUT_STAGE] = !vld_ff[OUT_STAGE] || rsp_tready;
      for (int i = OUT_STAGE - 1; i >= 0; i--) begin
         en_w[i] = !vld_ff[i] || en_w[i+1];
      end
      vld_in[0] = en_w[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         vld_in[i] = en_w[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   assign req_tready = en_w[0];

   hsvc_ring u_ring (
      .clock    (clock),
      .stage_en (en_w[1:0]),
      .pix_col  (req_tdata[COORD_BITS-1:0]),
      .pix_row  (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .cfg      (cfg),
      .in_ring  (inside_w)
   );

   hsvc_prep u_prep (
      .clock    (clock),
      .stage_en (en_w[1:0]),
      .blue_in  (req_tdata[2*COORD_BITS+CHAN_BITS-1:2*COORD_BITS]),
      .green_in (req_tdata[2*COORD_BITS+2*CHAN_BITS-1:2*COORD_BITS+CHAN_BITS]),
      .red_in   (req_tdata[2*COORD_BITS+3*CHAN_BITS-1:2*COORD_BITS+2*CHAN_BITS]),
      .prep     (prep)
   );

   hsvc_div u_sat_div (
      .clock    (clock),
      .stage_en (en_w[DIV_LAST:DIV_FIRST]),
      .num      (prep.s_num),
      .den      (prep.s_den),
      .quo      (s_quo)
   );

   hsvc_div u_hue_div (
      .clock    (clock),
      .stage_en (en_w[DIV_LAST:DIV_FIRST]),
      .num      (prep.h_num),
      .den      (prep.h_den),
      .quo      (h_quo)
   );

   // Sideband travels beside the divider stages.
   always_comb begin
      side_in.val     = prep.val;
      side_in.s_zero  = prep.s_zero;
      side_in.h_zero  = prep.h_zero;
      side_in.in_ring = inside_w;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (en_w[DIV_FIRST]) side_ff[0] <= side_in;
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (en_w[DIV_FIRST+k]) side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign side_last = side_ff[DIV_STAGES-1];

   // A pixel outside the ring is black: hue, saturation and value all zero.
   always_comb begin
      h_sel_w = side_last.h_zero ? '0 : h_quo;
      hue_in  = (h_sel_w >= HUE_WRAP) ? h_sel_w - HUE_WRAP : h_sel_w;
      sat_in  = side_last.s_zero ? '0 : s_quo;
      val_in  = side_last.val;
      if (!side_last.in_ring) begin
         hue_in = '0;
         sat_in = '0;
         val_in = '0;
      end
      if (cfg.hue_low > cfg.hue_high)
         hue_ok_w = (hue_in <= cfg.hue_high) || (hue_in >= cfg.hue_low && hue_in <= HUE_TOP);
      else
         hue_ok_w = (hue_in >= cfg.hue_low) && (hue_in <= cfg.hue_high);
      match_in = hue_ok_w
                 && (sat_in >= cfg.sat_min) && (sat_in <= cfg.sat_max)
                 && (val_in >= cfg.val_min) && (val_in <= cfg.val_max);
   end

   always_ff @(posedge clock) begin
      if (en_w[OUT_STAGE]) begin
         match_ff      <= match_in;
         inside_out_ff <= side_last.in_ring;
         hue_ff        <= hue_in;
         sat_ff        <= sat_in;
         val_ff        <= val_in;
      end
   end

   assign rsp_tvalid = vld_ff[OUT_STAGE];
   assign rsp_tdata  = {(RSP_TDATA_BITS - RSP_BITS)'(0),
                        val_ff, sat_ff, hue_ff, inside_out_ff, match_ff};

   `HSVC_ASSERT_NOW(a_outside_black, vld_ff[OUT_STAGE] && !inside_out_ff, hue_ff == '0 && sat_ff == '0 && val_ff == '0)
   `HSVC_ASSERT_NOW(a_hue_range, vld_ff[OUT_STAGE], hue_ff <= HUE_TOP)
   `HSVC_ASSERT_NOW(a_dark_no_color, vld_ff[OUT_STAGE] && val_ff == '0, hue_ff == '0 && sat_ff == '0)
   `HSVC_ASSERT_NOW(a_ready_only_when_full, !req_tready, &vld_ff)
   `HSVC_ASSERT_NEXT(a_div_stall_holds, vld_ff[DIV_FIRST] && !en_w[DIV_FIRST], vld_ff[DIV_FIRST])

endmodule

// File: verif/ring_masked_hsv_color_classifier_tb.sv
// Self-checking testbench of the ring-masked HSV color classifier.
`timescale 1ns / 1ps
module ring_masked_hsv_color_classifier_tb;
   import hsvc_pkg::*;

   localparam int PIPE_DEPTH  = 7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REQ_PAD     = REQ_TDATA_BITS - REQ_BITS;
   localparam int RSP_PAD     = RSP_TDATA_BITS - RSP_BITS;
   localparam int COORD_TOP   = (1 << COORD_BITS) - 1;
   localparam int IDLE_PCT    = 24;

   // Packed high field first, so col lands in the low bits of req_tdata.
   typedef struct packed {
      logic [REQ_PAD-1:0]    pad;
      logic [CHAN_BITS-1:0]  red;
      logic [CHAN_BITS-1:0]  green;
      logic [CHAN_BITS-1:0]  blue;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } pixel_req_type;

   typedef struct packed {
      logic [RSP_PAD-1:0]   pad;
      logic [CHAN_BITS-1:0] val;
      logic [CHAN_BITS-1:0] sat;
      logic [CHAN_BITS-1:0] hue;
      logic                 in_ring;
      logic                 match;
   } pixel_class_type;

   typedef struct {
      logic [7:0]            hue_low;
      logic [7:0]            hue_high;
      logic [15:0]           sat_bounds;
      logic [15:0]           val_bounds;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [COORD_BITS-1:0] inner_r;
      logic [COORD_BITS-1:0] outer_r;
   } hsv_regs_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata   = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   hsv_regs_type    shadow_regs;
   pixel_class_type predicted_classes[$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   logic            steady_flow    = 1'b0;

   ring_masked_hsv_color_classifier i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   function automatic hsv_regs_type default_regs();
      hsv_regs_type s;
      s.hue_low    = 8'd0;
      s.hue_high   = 8'd179;
      s.sat_bounds = 16'hFF00;
      s.val_bounds = 16'hFF00;
      s.center_x   = 10'd320;
      s.center_y   = 10'd240;
      s.inner_r    = 10'd0;
      s.outer_r    = 10'd1023;
      return s;
   endfunction

   function automatic logic [31:0] reg_value(logic [REG_INDEX_BITS-1:0] idx);
      case (idx)
         REG_HUE_LOW:    return 32'(shadow_regs.hue_low);
         REG_HUE_HIGH:   return 32'(shadow_regs.hue_high);
         REG_SAT_BOUNDS: return 32'(shadow_regs.sat_bounds);
         REG_VAL_BOUNDS: return 32'(shadow_regs.val_bounds);
         REG_CENTER_X:   return 32'(shadow_regs.center_x);
         REG_CENTER_Y:   return 32'(shadow_regs.center_y);
         REG_INNER_R:    return 32'(shadow_regs.inner_r);
         default:        return 32'(shadow_regs.outer_r);
      endcase
   endfunction

   // Ring test, black masking, 8-bit HSV and bound tests for one pixel.
   function automatic pixel_class_type classify_pixel(pixel_req_type px);
      int dx, dy, d, ri, ro, b, g, r, mx, mn, df, num, base, n, hue, sat, hl, hh;
      logic in_ring, hue_ok, sat_ok, val_ok;
      pixel_class_type res;
      dx = int'(px.col) - int'(shadow_regs.center_x);
      dy = int'(px.row) - int'(shadow_regs.center_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d  = dx * dx + dy * dy;
      ri = int'(shadow_regs.inner_r);
      ro = int'(shadow_regs.outer_r);
      in_ring = (d <= ro * ro) && (d > ri * ri);
      b = in_ring ? int'(px.blue)  : 0;
      g = in_ring ? int'(px.green) : 0;
      r = in_ring ? int'(px.red)   : 0;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      df  = mx - mn;
      sat = (mx == 0) ? 0 : (510 * df + mx) / (2 * mx);
      if (df == 0) begin
         hue = 0;
      end else begin
         // red wins ties over green, green over blue
         if (mx == r) begin
            base = 0;
            num  = g - b;
         end else if (mx == g) begin
            base = 60;
            num  = b - r;
         end else begin
            base = 120;
            num  = r - g;
         end
         n = base * df + 30 * num;
         if (n < 0) n += 180 * df;
         hue = (2 * n + df) / (2 * df);
         if (hue >= 180) hue -= 180;
      end
      hl = int'(shadow_regs.hue_low);
      hh = int'(shadow_regs.hue_high);
      if (hl > hh)
         hue_ok = (hue <= hh) || (hue >= hl && hue <= int'(HUE_TOP));
      else
         hue_ok = (hue >= hl) && (hue <= hh);
      sat_ok = (sat >= int'(shadow_regs.sat_bounds[7:0]))
               && (sat <= int'(shadow_regs.sat_bounds[15:8]));
      val_ok = (mx >= int'(shadow_regs.val_bounds[7:0]))
               && (mx <= int'(shadow_regs.val_bounds[15:8]));
      res         = '0;
      res.match   = hue_ok && sat_ok && val_ok;
      res.in_ring = in_ring;
      res.hue     = hue[7:0];
      res.sat     = sat[7:0];
      res.val     = mx[7:0];
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_class_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (predicted_classes.size() == 0) begin
            $error("rsp: unexpected result %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = predicted_classes.pop_front();
            if (got.match !== want.match) begin
               $error("color_match: expected %0d, got %0d", want.match, got.match);
               mismatch_count++;
            end
            if (got.in_ring !== want.in_ring) begin
               $error("inside_ring: expected %0d, got %0d", want.in_ring, got.in_ring);
               mismatch_count++;
            end
            if (got.hue !== want.hue) begin
               $error("hue_out: expected %0d, got %0d", want.hue, got.hue);
               mismatch_count++;
            end
            if (got.sat !== want.sat) begin
               $error("sat_out: expected %0d, got %0d", want.sat, got.sat);
               mismatch_count++;
            end
            if (got.val !== want.val) begin
               $error("val_out: expected %0d, got %0d", want.val, got.val);
               mismatch_count++;
            end
         end
      end
   end

   // Send one pixel request, with a random idle gap first unless steady_flow is set.
   task automatic send_pixel(input pixel_req_type px);
      int gap;
      gap = 0;
      if (!steady_flow)
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      px.pad     = '0;
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      predicted_classes.push_back(classify_pixel(px));
   endtask

   task automatic send_rgb(input int col, input int row, input int b, input int g, input int r);
      pixel_req_type px;
      px       = '0;
      px.col   = col[COORD_BITS-1:0];
      px.row   = row[COORD_BITS-1:0];
      px.blue  = b[7:0];
      px.green = g[7:0];
      px.red   = r[7:0];
      send_pixel(px);
   endtask

   // Drop valid and wait for the pipeline to drain.
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (predicted_classes.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_HUE_LOW:    shadow_regs.hue_low    = value[7:0];
         REG_HUE_HIGH:   shadow_regs.hue_high   = value[7:0];
         REG_SAT_BOUNDS: shadow_regs.sat_bounds = value[15:0];
         REG_VAL_BOUNDS: shadow_regs.val_bounds = value[15:0];
         REG_CENTER_X:   shadow_regs.center_x   = value[COORD_BITS-1:0];
         REG_CENTER_Y:   shadow_regs.center_y   = value[COORD_BITS-1:0];
         REG_INNER_R:    shadow_regs.inner_r    = value[COORD_BITS-1:0];
         default:        shadow_regs.outer_r    = value[COORD_BITS-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic check_reg(input logic [REG_INDEX_BITS-1:0] idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (csr_prdata !== reg_value(idx)) begin
         $error("prdata reg %0d: expected %h, got %h", idx, reg_value(idx), csr_prdata);
         mismatch_count++;
      end
      @(posedge clock);
   endtask

   // Write every register, then read each one back.
   task automatic apply_settings(input hsv_regs_type s);
      write_reg(REG_HUE_LOW,    32'(s.hue_low));
      write_reg(REG_HUE_HIGH,   32'(s.hue_high));
      write_reg(REG_SAT_BOUNDS, 32'(s.sat_bounds));
      write_reg(REG_VAL_BOUNDS, 32'(s.val_bounds));
      write_reg(REG_CENTER_X,   32'(s.center_x));
      write_reg(REG_CENTER_Y,   32'(s.center_y));
      write_reg(REG_INNER_R,    32'(s.inner_r));
      write_reg(REG_OUTER_R,    32'(s.outer_r));
      for (int i = 0; i < 8; i++) check_reg(i[REG_INDEX_BITS-1:0]);
   endtask

   task automatic test_register_defaults();
      for (int i = 0; i < 8; i++) check_reg(i[REG_INDEX_BITS-1:0]);
   endtask

   // Default settings: colors at a pixel just off the center, then the center and two corners.
   task automatic test_color_extremes();
      send_rgb(321, 240,   0,   0,   0);  // black
      send_rgb(321, 240, 255, 255, 255);  // white
      send_rgb(321, 240,   0,   0, 255);  // pure red
      send_rgb(321, 240,   0, 255,   0);  // pure green
      send_rgb(321, 240, 255,   0,   0);  // pure blue
      send_rgb(321, 240,   1,   0, 255);  // red max, hue rounds to the wrap
      send_rgb(321, 240,  10, 200, 200);  // red and green tie
      send_rgb(321, 240, 200, 200,  10);  // green and blue tie
      send_rgb(321, 240,   1,   1,   2);  // dim pixel, small df
      send_rgb(320, 240, 255, 128,  64);  // center pixel lies outside
      send_rgb(  0,   0,  90, 180,  30);
      send_rgb(1023, 1023, 30, 60, 240);
      drain_pixels();
   endtask

   task automatic test_ring_edges();
      hsv_regs_type s;
      s          = default_regs();
      s.center_x = 10'd100;
      s.center_y = 10'd100;
      s.inner_r  = 10'd10;
      s.outer_r  = 10'd20;
      apply_settings(s);
      send_rgb(110, 100, 40, 80, 160);  // on the inner edge: out
      send_rgb(100, 111, 40, 80, 160);  // just past the inner edge: in
      send_rgb( 88, 100, 40, 80, 160);
      send_rgb(100, 120, 40, 80, 160);  // on the outer edge: in
      send_rgb(121, 100, 40, 80, 160);  // past the outer edge: out
      drain_pixels();
      // empty ring: inner not below outer
      s.inner_r = 10'd20;
      apply_settings(s);
      send_rgb(115, 100, 40, 80, 160);
      drain_pixels();
   endtask

   task automatic test_band_edges();
      hsv_regs_type s;
      s            = default_regs();
      s.hue_low    = 8'd170;
      s.hue_high   = 8'd10;
      s.sat_bounds = 16'hFF20;
      s.val_bounds = 16'hF010;
      apply_settings(s);
      send_rgb(321, 240,   0,   0, 255);  // hue 0 in the wrapped band
      send_rgb(321, 240,  60,   0, 255);  // hue near 173
      send_rgb(321, 240,   0, 255,   0);  // hue 60 outside the band
      send_rgb(321, 240,   0,   0, 250);
      drain_pixels();
      // inverted saturation bounds and a lower hue bound above the hue range
      s.hue_low    = 8'd200;
      s.hue_high   = 8'd220;
      s.sat_bounds = 16'h10F0;
      apply_settings(s);
      send_rgb(321, 240, 0, 0, 255);
      send_rgb(321, 240, 0, 100, 255);
      drain_pixels();
   endtask

   function automatic hsv_regs_type random_settings();
      hsv_regs_type s;
      int lo;
      s.hue_low  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 179));
      s.hue_high = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 179));
      lo = $urandom_range(0, 200);
      s.sat_bounds = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                     : {8'($urandom_range(lo, 255)), 8'(lo)};
      lo = $urandom_range(0, 200);
      s.val_bounds = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                     : {8'($urandom_range(lo, 255)), 8'(lo)};
      s.center_x = COORD_BITS'($urandom_range(0, COORD_TOP));
      s.center_y = COORD_BITS'($urandom_range(0, COORD_TOP));
      s.outer_r  = COORD_BITS'($urandom_range(1, COORD_TOP));
      s.inner_r  = ($urandom_range(0, 7) == 0) ? COORD_BITS'($urandom_range(0, COORD_TOP))
                   : COORD_BITS'($urandom_range(0, int'(s.outer_r) - 1));
      return s;
   endfunction

   function automatic int near_coord(int center, int radius);
      int c;
      c = center + $urandom_range(0, 2 * radius + 4) - radius - 2;
      if (c < 0) c = 0;
      if (c > COORD_TOP) c = COORD_TOP;
      return c;
   endfunction

   function automatic int random_chan();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic test_random_traffic();
      hsv_regs_type s;
      int col, row, b, g, r, rad;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               s            = default_regs();
               s.hue_low    = 8'd0;
               s.hue_high   = 8'd0;
               s.sat_bounds = 16'h0000;
               s.val_bounds = 16'h0000;
               s.center_x   = '0;
               s.center_y   = '0;
               s.inner_r    = '0;
               s.outer_r    = '0;
            end
            1: begin
               s            = default_regs();
               s.hue_low    = 8'hFF;
               s.hue_high   = 8'hFF;
               s.sat_bounds = 16'hFFFF;
               s.val_bounds = 16'hFFFF;
               s.center_x   = COORD_BITS'(COORD_TOP);
               s.center_y   = COORD_BITS'(COORD_TOP);
               s.outer_r    = COORD_BITS'(COORD_TOP);
            end
            2:       s = default_regs();
            default: s = random_settings();
         endcase
         apply_settings(s);
         // run one phase without any idling on either side
         steady_flow <= (phase == 2);
         rad = (int'(shadow_regs.outer_r) > 300) ? 300 : int'(shadow_regs.outer_r);
         for (int k = 0; k < 250; k++) begin
            if ($urandom_range(0, 9) < 7) begin
               col = near_coord(int'(shadow_regs.center_x), rad);
               row = near_coord(int'(shadow_regs.center_y), rad);
            end else begin
               col = $urandom_range(0, COORD_TOP);
               row = $urandom_range(0, COORD_TOP);
            end
            b = random_chan();
            g = random_chan();
            r = random_chan();
            if ($urandom_range(0, 15) == 0) begin
               g = b;
               r = b;
            end
            send_rgb(col, row, b, g, r);
         end
         drain_pixels();
         steady_flow <= 1'b0;
      end
   endtask

   initial begin
      shadow_regs = default_regs();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_color_extremes();
      test_ring_edges();
      test_band_edges();
      test_random_traffic();
      drain_pixels();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/hsvc_pkg.sv
hw/rtl/hsvc_csr.sv
hw/rtl/hsvc_ring.sv
hw/rtl/hsvc_prep.sv
hw/rtl/hsvc_div.sv
hw/rtl/ring_masked_hsv_color_classifier.sv
verif/ring_masked_hsv_color_classifier_tb.sv
